FILE: src/mhpq_pkg.sv
// Shared types and constants for the max-heap priority queue.
package mhpq_pkg;

   localparam int CAPACITY_DEF  = 64;
   localparam int KEY_WIDTH_DEF = 32;
   localparam int KEY_FIELD_W   = 32;
   localparam int COUNT_FIELD_W = 7;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_DEL_LOAD,
      S_UP_PROBE,
      S_UP_STEP,
      S_DN_PROBE,
      S_DN_STEP,
      S_FINISH
   } state_type;

   // Controller to datapath strobes
   typedef struct packed {
      logic capture;
      logic start;
      logic ins_begin;
      logic del_begin;
      logic del_load;
      logic up_probe;
      logic up_step;
      logic dn_probe;
      logic dn_step;
      logic finish;
   } ctl_cmd_type;

   // Datapath to controller flags
   typedef struct packed {
      logic is_del;
      logic full;
      logic empty;
      logic single;
      logic pos_zero;
      logic up_move;
      logic no_child;
      logic dn_move;
      logic out_free;
   } dp_stat_type;

endpackage

FILE: src/mhpq_if.sv
// Request and response channel interfaces for the heap queue.
interface mhpq_req_if;
   import mhpq_pkg::*;
   logic                   valid;
   logic                   ready;
   op_type                 cmd;
   logic [KEY_FIELD_W-1:0] key;

   modport source (output valid, output cmd, output key, input ready);
   modport sink   (input valid, input cmd, input key, output ready);
endinterface

interface mhpq_rsp_if;
   import mhpq_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [KEY_FIELD_W-1:0]   top_key;
   logic                     top_valid;
   logic [COUNT_FIELD_W-1:0] entry_count;
   status_type               status;

   modport source (output valid, output top_key, output top_valid, output entry_count,
                   output status, input ready);
   modport sink   (input valid, input top_key, input top_valid, input entry_count,
                   input status, output ready);
endinterface

FILE: src/max_heap_priority_queue_top.sv
// Bounded binary max-heap priority queue, top level.
//
// req_chan carries one transaction per operation: cmd selects insert of key or delete of
// the current maximum. rsp_chan returns exactly one transaction per request with the
// largest key held afterward (zero when empty), a non-empty flag, the entry count and
// a status: ok, insert refused because full, or delete on an empty heap.
// Operations run one at a time. A request is taken only while the block is idle; a refused
// request or the delete of the last key goes from the start step straight to the final
// step, while other operations sift through the tree first. The response is registered
// in the final step, and the block then returns to idle for the next request.
// Each tree level takes a registered read of the key store, then a compare
// and one write. The store has one write port and two read ports, so a sift-down reads
// both children of a node together.
// Reset empties the heap at once; the key store itself is not cleared, as only entries
// below the count are ever used. The response sits in an output register: the next
// request is accepted while it waits, and a stalled receiver only holds the block in
// its final step until the register frees.
module max_heap_priority_queue_top #(
   parameter int CAPACITY  = mhpq_pkg::CAPACITY_DEF,
   parameter int KEY_WIDTH = mhpq_pkg::KEY_WIDTH_DEF
) (
   input logic        clock,
   input logic        reset,
   mhpq_req_if.sink   req_chan,
   mhpq_rsp_if.source rsp_chan
);
   import mhpq_pkg::*;

   ctl_cmd_type ctl;
   dp_stat_type stat;

   mhpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .ctl       (ctl),
      .stat      (stat)
   );

   mhpq_datapath #(
      .CAPACITY  (CAPACITY),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .stat            (stat),
      .req_cmd         (req_chan.cmd),
      .req_key         (req_chan.key),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_top_key     (rsp_chan.top_key),
      .rsp_top_valid   (rsp_chan.top_valid),
      .rsp_entry_count (rsp_chan.entry_count),
      .rsp_status      (rsp_chan.status)
   );
endmodule

FILE: src/mhpq_ram.sv
// Generic RAM: one write port, two registered read ports.
module mhpq_ram #(
   parameter int WIDTH = mhpq_pkg::KEY_WIDTH_DEF,
   parameter int DEPTH = mhpq_pkg::CAPACITY_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;
endmodule

FILE: src/mhpq_datapath.sv
// Heap datapath: key store, sift position, count, compare logic and response register.
module mhpq_datapath #(
   parameter int CAPACITY  = mhpq_pkg::CAPACITY_DEF,
   parameter int KEY_WIDTH = mhpq_pkg::KEY_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mhpq_pkg::ctl_cmd_type              ctl,
   output mhpq_pkg::dp_stat_type              stat,
   input  mhpq_pkg::op_type                   req_cmd,
   input  logic [mhpq_pkg::KEY_FIELD_W-1:0]   req_key,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mhpq_pkg::KEY_FIELD_W-1:0]   rsp_top_key,
   output logic                               rsp_top_valid,
   output logic [mhpq_pkg::COUNT_FIELD_W-1:0] rsp_entry_count,
   output mhpq_pkg::status_type               rsp_status
);
   import mhpq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = AW + 2;

   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        pos_ff, pos_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [KEY_WIDTH-1:0] root_ff, root_in;
   op_type               op_ff, op_in;
   status_type           status_ff, status_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [KEY_FIELD_W-1:0]   rsp_key_ff, rsp_key_in;
   logic                     rsp_tv_ff, rsp_tv_in;
   logic [COUNT_FIELD_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   status_type               rsp_st_ff, rsp_st_in;

   logic                 wr_en;
   logic [AW-1:0]        rd_addr_a;
   logic [KEY_WIDTH-1:0] wr_data;
   logic [KEY_WIDTH-1:0] qa, qb;

   logic [AW-1:0]        parent;
   logic [IW-1:0]        left_idx, right_idx;
   logic                 right_out;
   logic                 pick_right;
   logic [KEY_WIDTH-1:0] pick_val;
   logic [AW-1:0]        pick_idx;
   logic                 wr_key, wr_move;
   logic                 rsp_load;

   assign parent     = (pos_ff - AW'(1)) >> 1;
   assign left_idx   = IW'({pos_ff, 1'b1});
   assign right_idx  = left_idx + IW'(1);
   assign right_out  = right_idx >= IW'(count_ff);
   assign pick_right = !right_out && (qa < qb);
   assign pick_val   = pick_right ? qb : qa;
   assign pick_idx   = pick_right ? AW'(right_idx) : AW'(left_idx);

   always_comb begin
      stat.is_del   = (op_ff == OP_DELETE);
      stat.full     = (count_ff == CW'(CAPACITY));
      stat.empty    = (count_ff == '0);
      stat.single   = (count_ff == CW'(1));
      stat.pos_zero = (pos_ff == '0);
      stat.up_move  = (qa < key_ff);
      stat.no_child = left_idx >= IW'(count_ff);
      // lone left child swaps only when strictly larger; two children swap unless both smaller
      stat.dn_move  = right_out ? (key_ff < qa) : !((qa < key_ff) && (qb < key_ff));
      stat.out_free = !rsp_valid_ff || rsp_ready;
   end

   assign wr_key  = (ctl.up_probe && stat.pos_zero) || (ctl.up_step && !stat.up_move) ||
                    (ctl.dn_probe && stat.no_child) || (ctl.dn_step && !stat.dn_move);
   assign wr_move = (ctl.up_step && stat.up_move) || (ctl.dn_step && stat.dn_move);
   assign wr_en   = wr_key || wr_move;

   always_comb begin
      if (wr_move) begin
         wr_data = ctl.up_step ? qa : pick_val;
      end else begin
         wr_data = key_ff;
      end
   end

   always_comb begin
      if (ctl.del_begin) begin
         rd_addr_a = AW'(count_ff - CW'(1));
      end else if (ctl.up_probe) begin
         rd_addr_a = parent;
      end else begin
         rd_addr_a = AW'(left_idx);
      end
   end

   mhpq_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (pos_ff),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (qa),
      .rd_addr_b (AW'(right_idx)),
      .rd_data_b (qb)
   );

   always_comb begin
      count_in  = count_ff;
      pos_in    = pos_ff;
      key_in    = key_ff;
      root_in   = root_ff;
      op_in     = op_ff;
      status_in = status_ff;

      if (ctl.capture) begin
         op_in  = req_cmd;
         key_in = KEY_WIDTH'(req_key);
      end
      if (ctl.start) begin
         if (!stat.is_del && stat.full) begin
            status_in = ST_FULL;
         end else if (stat.is_del && stat.empty) begin
            status_in = ST_EMPTY;
         end else begin
            status_in = ST_OK;
         end
      end
      if (ctl.ins_begin) begin
         pos_in   = AW'(count_ff);
         count_in = count_ff + CW'(1);
      end
      if (ctl.del_begin) begin
         pos_in   = '0;
         count_in = count_ff - CW'(1);
      end
      if (ctl.del_load) begin
         key_in = qa;
      end
      if (ctl.up_step && stat.up_move) begin
         pos_in = parent;
      end
      if (ctl.dn_step && stat.dn_move) begin
         pos_in = pick_idx;
      end
      // keep a copy of the root so the response needs no extra read
      if (wr_en && pos_ff == '0) begin
         root_in = wr_data;
      end
   end

   assign rsp_load = ctl.finish && stat.out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_tv_in    = rsp_tv_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_st_in    = rsp_st_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_key_in   = (count_ff != '0) ? KEY_FIELD_W'(root_ff) : '0;
         rsp_tv_in    = (count_ff != '0);
         rsp_cnt_in   = COUNT_FIELD_W'(count_ff);
         rsp_st_in    = status_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff     <= pos_in;
      key_ff     <= key_in;
      root_ff    <= root_in;
      op_ff      <= op_in;
      status_ff  <= status_in;
      rsp_key_ff <= rsp_key_in;
      rsp_tv_ff  <= rsp_tv_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_st_ff  <= rsp_st_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_top_key     = rsp_key_ff;
   assign rsp_top_valid   = rsp_tv_ff;
   assign rsp_entry_count = rsp_cnt_ff;
   assign rsp_status      = rsp_st_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("heap count above capacity");

   a_count_quiet: assert property (@(posedge clock) disable iff (reset)
      !ctl.ins_begin && !ctl.del_begin |=> $stable(count_ff))
      else $error("heap count changed outside insert or delete");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_load && status_ff == ST_FULL |-> count_ff == CW'(CAPACITY))
      else $error("full status reported on a heap with room");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_load && status_ff == ST_EMPTY |-> count_ff == '0)
      else $error("empty status reported on a non-empty heap");
endmodule

FILE: src/mhpq_ctrl.sv
// Heap controller: sequences insert sift-up and delete sift-down steps.
module mhpq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output mhpq_pkg::ctl_cmd_type ctl,
   input  mhpq_pkg::dp_stat_type stat
);
   import mhpq_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_START;
         end
         S_START: begin
            if (stat.is_del) begin
               if (stat.empty || stat.single) state_in = S_FINISH;
               else state_in = S_DEL_LOAD;
            end else begin
               if (stat.full) state_in = S_FINISH;
               else state_in = S_UP_PROBE;
            end
         end
         S_DEL_LOAD: state_in = S_DN_PROBE;
         S_UP_PROBE: begin
            state_in = stat.pos_zero ? S_FINISH : S_UP_STEP;
         end
         S_UP_STEP: begin
            state_in = stat.up_move ? S_UP_PROBE : S_FINISH;
         end
         S_DN_PROBE: begin
            state_in = stat.no_child ? S_FINISH : S_DN_STEP;
         end
         S_DN_STEP: begin
            state_in = stat.dn_move ? S_DN_PROBE : S_FINISH;
         end
         S_FINISH: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = (state_ff == S_IDLE);
      ctl.capture   = (state_ff == S_IDLE) && req_valid;
      ctl.start     = (state_ff == S_START);
      ctl.ins_begin = (state_ff == S_START) && !stat.is_del && !stat.full;
      ctl.del_begin = (state_ff == S_START) && stat.is_del && !stat.empty;
      ctl.del_load  = (state_ff == S_DEL_LOAD);
      ctl.up_probe  = (state_ff == S_UP_PROBE);
      ctl.up_step   = (state_ff == S_UP_STEP);
      ctl.dn_probe  = (state_ff == S_DN_PROBE);
      ctl.dn_step   = (state_ff == S_DN_STEP);
      ctl.finish    = (state_ff == S_FINISH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_capture_starts: assert property (@(posedge clock) disable iff (reset)
      ctl.capture |=> state_ff == S_START)
      else $error("accepted transaction did not start an operation");

   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FINISH && !stat.out_free |=> state_ff == S_FINISH)
      else $error("operation left finish before its response was stored");
endmodule

FILE: dv/tb_max_heap_priority_queue_top.sv
// Self-checking testbench for the max-heap priority queue top level.
module tb_max_heap_priority_queue_top;
   import mhpq_pkg::*;

   localparam int HEAP_DEPTH = CAPACITY_DEF;
   localparam int NUM_OPS    = 1600;

   typedef struct packed {
      op_type                 op;
      logic [KEY_FIELD_W-1:0] key;
   } heap_op_type;

   typedef struct packed {
      logic [KEY_FIELD_W-1:0]   top_key;
      logic                     top_valid;
      logic [COUNT_FIELD_W-1:0] entry_count;
      status_type               status;
   } heap_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mhpq_req_if req_if ();
   mhpq_rsp_if rsp_if ();

   max_heap_priority_queue_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Driven values, all known from time zero
   bit                     drv_valid = 1'b0;
   op_type                 drv_cmd   = OP_INSERT;
   bit [KEY_FIELD_W-1:0]   drv_key   = '0;
   bit                     rx_ready  = 1'b0;

   assign req_if.valid = drv_valid;
   assign req_if.cmd   = drv_cmd;
   assign req_if.key   = drv_key;
   assign rsp_if.ready = rx_ready;

   heap_op_type     pending_ops[$];
   heap_result_type expected_results[$];

   // Shadow heap
   logic [KEY_FIELD_W-1:0] heap_keys [HEAP_DEPTH];
   int                     held_keys = 0;

   int gen_count = 0;
   int gen_ops   = 0;
   int mismatches = 0;
   bit req_taken = 1'b0;

   int burst_left = 1;
   int gap_left   = 0;
   int rx_cycle   = 0;
   int stall_left = 0;
   heap_op_type     next_op;
   heap_result_type want;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

   function automatic void swap_keys(int a, int b);
      logic [KEY_FIELD_W-1:0] tmp;
      tmp          = heap_keys[a];
      heap_keys[a] = heap_keys[b];
      heap_keys[b] = tmp;
   endfunction

   function automatic heap_result_type predict_heap_op(op_type op,
                                                       logic [KEY_FIELD_W-1:0] key);
      heap_result_type res;
      int  pos;
      int  up;
      int  lc;
      int  rc;
      int  pick;
      bit  done;
      res.status = ST_OK;
      if (op == OP_INSERT) begin
         if (held_keys >= HEAP_DEPTH) begin
            res.status = ST_FULL;
         end else begin
            pos = held_keys;
            heap_keys[pos] = key;
            held_keys++;
            done = 1'b0;
            while (pos > 0 && !done) begin
               up = (pos - 1) / 2;
               if (heap_keys[up] < heap_keys[pos]) begin
                  swap_keys(up, pos);
                  pos = up;
               end else begin
                  done = 1'b1;
               end
            end
         end
      end else begin
         if (held_keys == 0) begin
            res.status = ST_EMPTY;
         end else begin
            held_keys--;
            if (held_keys > 0) begin
               heap_keys[0] = heap_keys[held_keys];
               pos  = 0;
               done = 1'b0;
               while (!done) begin
                  lc = 2 * pos + 1;
                  rc = lc + 1;
                  if (lc >= held_keys) begin
                     done = 1'b1;
                  end else if (rc >= held_keys) begin
                     // lone left child: move only on strictly greater
                     if (heap_keys[pos] < heap_keys[lc]) swap_keys(pos, lc);
                     done = 1'b1;
                  end else if (heap_keys[lc] < heap_keys[pos] &&
                               heap_keys[rc] < heap_keys[pos]) begin
                     done = 1'b1;
                  end else begin
                     // ties between children go left; equal child still swaps
                     pick = (heap_keys[lc] < heap_keys[rc]) ? rc : lc;
                     swap_keys(pos, pick);
                     pos = pick;
                  end
               end
            end
         end
      end
      res.top_key     = (held_keys > 0) ? heap_keys[0] : '0;
      res.top_valid   = (held_keys > 0);
      res.entry_count = COUNT_FIELD_W'(held_keys);
      return res;
   endfunction

   function automatic logic [KEY_FIELD_W-1:0] pick_key();
      int sel;
      logic [KEY_FIELD_W-1:0] k;
      sel = $urandom_range(0, 9);
      if (sel <= 3) begin
         k = KEY_FIELD_W'($urandom_range(0, 15));  // dense range to force ties
      end else if (sel == 4) begin
         k = ($urandom_range(0, 1) == 1) ? '1 : '0;
      end else if (sel == 5) begin
         k = KEY_FIELD_W'(1) << $urandom_range(0, KEY_FIELD_W - 1);
         if ($urandom_range(0, 1) == 1) k = ~k;
      end else begin
         k = $urandom;
      end
      return k;
   endfunction

   task automatic queue_op(op_type op, logic [KEY_FIELD_W-1:0] key);
      heap_op_type item;
      item.op  = op;
      item.key = key;
      pending_ops.push_back(item);
      gen_ops++;
      if (op == OP_INSERT && gen_count < HEAP_DEPTH) gen_count++;
      if (op == OP_DELETE && gen_count > 0) gen_count--;
   endtask

   task automatic note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
   endtask

   // Stimulus and end of run
   initial begin
      int mode;
      int len;
      // directed: empty delete, extremes, ties, drain through empty
      queue_op(OP_DELETE, 32'h1234_5678);
      queue_op(OP_INSERT, 32'h0000_0000);
      queue_op(OP_DELETE, 32'hFFFF_FFFF);
      queue_op(OP_INSERT, 32'hFFFF_FFFF);
      queue_op(OP_INSERT, 32'h0000_0000);
      queue_op(OP_INSERT, 32'h8000_0000);
      queue_op(OP_INSERT, 32'h7FFF_FFFF);
      queue_op(OP_INSERT, 32'hFFFF_FFFF);
      queue_op(OP_INSERT, 32'hAAAA_AAAA);
      queue_op(OP_INSERT, 32'h5555_5555);
      repeat (3) queue_op(OP_INSERT, 32'h0000_0005);
      repeat (11) queue_op(OP_DELETE, 32'h0);

      // random: fill to full, drain to empty, and mixed stretches
      while (gen_ops < NUM_OPS) begin
         mode = $urandom_range(0, 3);
         if (mode == 0) begin
            while (gen_count < HEAP_DEPTH) queue_op(OP_INSERT, pick_key());
            repeat ($urandom_range(1, 3)) queue_op(OP_INSERT, pick_key());
         end else if (mode == 1) begin
            while (gen_count > 0) queue_op(OP_DELETE, $urandom);
            repeat ($urandom_range(1, 2)) queue_op(OP_DELETE, $urandom);
         end else begin
            len = $urandom_range(20, 80);
            repeat (len) begin
               if ($urandom_range(0, 99) < 55) queue_op(OP_INSERT, pick_key());
               else queue_op(OP_DELETE, $urandom);
            end
         end
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_ops.size() > 0 || drv_valid) @(posedge clock);
      while (expected_results.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Request driver: bursts with random gaps
   always @(negedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
      end else if (!drv_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left   = gap_left - 1;
            drv_valid <= 1'b0;
         end else if (pending_ops.size() > 0) begin
            next_op    = pending_ops.pop_front();
            drv_valid <= 1'b1;
            drv_cmd   <= next_op.op;
            drv_key   <= next_op.key;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            end else begin
               burst_left = burst_left - 1;
            end
         end else begin
            drv_valid <= 1'b0;
         end
      end
   end

   // Response stall pattern: rotates through always-ready, light, heavy and long-run stalls
   always @(negedge clock) begin
      rx_cycle = rx_cycle + 1;
      unique case ((rx_cycle / 300) % 4)
         0: begin
            rx_ready <= 1'b1;
         end
         1: begin
            rx_ready <= ($urandom_range(0, 3) != 0);
         end
         2: begin
            rx_ready <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            if (stall_left > 0) begin
               stall_left = stall_left - 1;
               rx_ready  <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
               stall_left = $urandom_range(1, 25);
               rx_ready  <= 1'b0;
            end else begin
               rx_ready <= 1'b1;
            end
         end
      endcase
   end

   // Monitor: predict on request transaction, check on response transaction
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            req_taken = 1'b1;
            expected_results.push_back(predict_heap_op(req_if.cmd, req_if.key));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
               note_mismatch($sformatf("unexpected response: key=%h v=%0d n=%0d st=%0d",
                  rsp_if.top_key, rsp_if.top_valid, rsp_if.entry_count, rsp_if.status));
            end else begin
               want = expected_results.pop_front();
               if (rsp_if.top_key !== want.top_key || rsp_if.top_valid !== want.top_valid ||
                   rsp_if.entry_count !== want.entry_count || rsp_if.status !== want.status)
               begin
                  note_mismatch($sformatf(
                     "mismatch: exp key=%h v=%0d n=%0d st=%0d got key=%h v=%0d n=%0d st=%0d",
                     want.top_key, want.top_valid, want.entry_count, want.status,
                     rsp_if.top_key, rsp_if.top_valid, rsp_if.entry_count, rsp_if.status));
               end
            end
         end
      end
   end

endmodule
